@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SSET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SSET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/sset_pkg.sv @@
// Package with types and constants of the sorted set engine.
package sset_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;
  localparam int STAT_W    = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STAT_W-1:0] STAT_MISS = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    key_t key;
  } cell_ctl_t;

endpackage

@@ rtl/sset_cell.sv @@
// One storage cell of the sorted key chain: compare and shift.
module sset_cell
  import sset_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,       // this slot holds a key
  input  logic      prev_lt,   // left neighbor's key is below the search key
  input  key_t      prev_key,  // left neighbor's key
  output key_t      key_r,
  output logic      lt_r,
  output logic      eq_r
);

  key_t key_nxt;
  logic lt_nxt;
  logic eq_nxt;

  always_comb begin
    key_nxt = key_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.cmp_en) begin
      lt_nxt = occ && (key_r < ctl.key);
      eq_nxt = occ && (key_r == ctl.key);
    end
    // Cells below the insert point keep their key; the insert point takes the
    // new key and every cell above it takes its left neighbor's key.
    if (ctl.shift_en && !lt_r) begin
      key_nxt = prev_lt ? ctl.key : prev_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

endmodule

@@ rtl/sorted_set_insert_member_core.sv @@
// Top level of the sorted set engine: sequencer, count and chain of cells.
//
// Usage: a set of up to CAPACITY distinct signed 32-bit keys kept in
// ascending order in a row of compare-and-shift cells.
// Input channel in_*: in_tdata carries the key, in_tuser[0] the operation
// (0 membership query, 1 insert). Result channel out_*: out_tdata[1:0] is
// the status (query: 0 absent, 1 found; insert: 0 duplicate, 1 inserted,
// 2 rejected full), out_tdata[8:2] the number of keys held after the item.
// Timing: in the transfer cycle every cell compares its key with the
// broadcast key and registers its below and match flags; in the compare
// state, once the output is free, the flags are combined, the insert
// shift happens in all cells at once and the result and out_tvalid are
// registered. No new item is taken until the last has left that state,
// as each item needs its compare-then-shift pass. Every item gives one result.
// Reset: the key count clears to zero; the cells need no clearing since
// slots at or beyond the count are never used.
// Stall: while a result waits on out_tready the next item is still taken
// and compared; it then holds in the compare step until the output frees.
module sorted_set_insert_member_core
  import sset_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_value
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [8:2] stored_count, rest zero
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  cnt_t        count_r, count_nxt;
  key_t        key_r;
  logic        op_r;
  logic        out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_stat_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;

  cell_ctl_t           ctl;
  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] occ_vec;

  logic in_xfer;
  logic emit;
  logic hit;
  logic full;
  logic do_shift;
  logic [STAT_W-1:0] status;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign emit      = (state_r == S_CMP) && (!out_valid_r || out_tready);
  assign hit       = |eq_vec;
  assign full      = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    if (op_r == OP_QUERY) begin
      status = hit ? STAT_HIT : STAT_MISS;
    end else if (hit) begin
      status = STAT_MISS;
    end else if (full) begin
      status = STAT_FULL;
    end else begin
      status = STAT_HIT;
    end
  end

  assign do_shift = emit && (op_r == OP_INSERT) && !hit && !full;

  assign ctl.cmp_en   = in_xfer;
  assign ctl.shift_en = do_shift;
  assign ctl.key      = in_xfer ? key_t'(in_tdata) : key_r;

  // Chain of cells; cell 0 has nothing below it.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ_vec[gi] = (CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_first
        sset_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (occ_vec[gi]),
          .prev_lt  (1'b1),
          .prev_key (key_r),
          .key_r    (cell_key[gi]),
          .lt_r     (lt_vec[gi]),
          .eq_r     (eq_vec[gi])
        );
      end else begin : g_rest
        sset_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (occ_vec[gi]),
          .prev_lt  (lt_vec[gi-1]),
          .prev_key (cell_key[gi-1]),
          .key_r    (cell_key[gi]),
          .lt_r     (lt_vec[gi]),
          .eq_r     (eq_vec[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (emit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (do_shift) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r <= key_t'(in_tdata);
      op_r  <= in_tuser[0];
    end
    if (emit) begin
      out_stat_r <= status;
      out_cnt_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - STAT_W - OUT_CNT_W){1'b0}}, out_cnt_r, out_stat_r};

  `SSET_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CNT_W'(CAPACITY)),
    "key count above capacity")
  `SSET_ASSERT(a_lt_prefix,
    (state_r == S_CMP) |-> ((lt_vec & ~{lt_vec[CAPACITY-2:0], 1'b1}) == '0),
    "below-key flags do not form a prefix of the chain")
  `SSET_ASSERT(a_single_match, (state_r == S_CMP) |-> $onehot0(eq_vec),
    "more than one cell matches the key")
  `SSET_ASSERT(a_full_holds, (emit && status == STAT_FULL) |=> $stable(count_r),
    "count changed on a rejected insert")

endmodule
